// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, pipeline depth and status codes for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // input and output field widths
  localparam int QW = 16;
  localparam int VW = 32;

  // exact numerator of q*(0,v)*conj(q), signed
  localparam int NUM_W = 68;
  // numerator magnitude, below 2^65
  localparam int MAG_W = NUM_W - 1;
  // divisor 2n, n below or equal to 2^32
  localparam int DIV_W = 34;
  // quotient bits, one divider stage each
  localparam int DIV_STEPS = 32;

  // stages before the divider, divider stages with its entry, output stage
  localparam int PRE_STAGES = 6;
  localparam int LAT = PRE_STAGES + DIV_STEPS + 1 + 1;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  // saturation limits of a Q16.16 result
  localparam logic [VW-1:0] POS_LIM = 32'h7FFF_FFFF;
  localparam logic [VW-1:0] NEG_LIM = 32'h8000_0000;

endpackage

// ===== rtl/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q16.16 vector by a Q2.14 quaternion as q*(0,v)*q^-1, dividing by
// the squared norm so non-unit quaternions still rotate, with rounding and
// saturation.
// ----------------------------------------------------------------------------
// One item is taken per clock while the output is not stalled; the depth
// is set by the restoring divider, one quotient bit per stage over 32
// stages, behind six stages of multiplies and wide adds. A stall on the
// output holds the whole pipeline, nothing is dropped. Status 1 flags an
// all-zero quaternion (vector reads zero), status 2 a clamped component.
module quaternion_vector_rotate (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rot_x, rot_y, rot_z
  output logic [95:0]  m_tdata,
  // status
  output logic [1:0]   m_tuser
);
  import qvr_pkg::*;

  // pipeline control
  logic           adv;
  logic [LAT-1:0] vld;

  // input unpack
  logic signed [QW-1:0] in_q [4];
  logic signed [VW-1:0] in_v [3];

  // stage 1: squares, dot and cross products
  logic signed [31:0] m_sq [4];
  logic signed [47:0] m_d  [3];
  logic signed [47:0] m_c  [6];
  logic [30:0]          sq1 [4];
  logic signed [47:0]   pd1 [3];
  logic signed [47:0]   pc1 [6];
  logic signed [QW-1:0] q1  [4];
  logic signed [VW-1:0] v1  [3];

  // stage 2: norm, scalar, dot and cross
  logic [32:0]          n2;
  logic signed [33:0]   s2;
  logic signed [49:0]   d2;
  logic signed [48:0]   cr2 [3];
  logic signed [QW-1:0] q2  [4];
  logic signed [VW-1:0] v2  [3];

  // stage 3: wide products
  logic signed [65:0] m_a [3];
  logic signed [65:0] m_b [3];
  logic signed [64:0] m_e [3];
  logic signed [65:0] a3  [3];
  logic signed [65:0] b3  [3];
  logic signed [64:0] e3  [3];
  logic [32:0]        n3;

  // stage 4: numerator
  logic signed [NUM_W-1:0] num4 [3];
  logic [32:0]             n4;

  // stage 5: sign and magnitude
  logic [NUM_W-1:0] m_mag [3];
  logic [MAG_W-1:0] mag5  [3];
  logic [2:0]       neg5;
  logic [32:0]      n5;

  // stage 6: dividend 2|num|+n and divisor 2n
  logic [NUM_W-1:0] x6 [3];
  logic [DIV_W-1:0] dv6;
  logic [2:0]       neg6;
  logic             zero6;

  // divider stages, entry 0 is the loaded stage
  logic [NUM_W-1:0] m_lim [3];
  logic [DIV_W-1:0] dr   [DIV_STEPS+1][3];
  logic [VW-1:0]    dxl  [DIV_STEPS+1][3];
  logic [VW-1:0]    dq   [DIV_STEPS+1][3];
  logic [DIV_W-1:0] ddv  [DIV_STEPS+1];
  logic [2:0]       dneg [DIV_STEPS+1];
  logic [2:0]       dsat [DIV_STEPS+1];
  logic             dzero [DIV_STEPS+1];
  logic [DIV_W:0]   m_t  [DIV_STEPS][3];
  logic [DIV_W:0]   m_r  [DIV_STEPS][3];
  logic             m_ge [DIV_STEPS][3];

  // output stage
  logic [VW-1:0] m_res [3];
  logic [VW-1:0] rot   [3];
  logic [1:0]    stat;

  assign adv      = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {rot[2], rot[1], rot[0]};
  assign m_tuser  = stat;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_q[i] = s_tdata[i*QW +: QW];
    end
    for (int i = 0; i < 3; i++) begin
      in_v[i] = s_tdata[4*QW + i*VW +: VW];
    end
  end

  // products of the input fields
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m_sq[i] = in_q[i] * in_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      m_d[i] = in_q[i+1] * in_v[i];
    end
    m_c[0] = in_q[2] * in_v[2];
    m_c[1] = in_q[3] * in_v[1];
    m_c[2] = in_q[3] * in_v[0];
    m_c[3] = in_q[1] * in_v[2];
    m_c[4] = in_q[1] * in_v[1];
    m_c[5] = in_q[2] * in_v[0];
  end

  // scaled vector, dot and cross terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_a[i] = s2 * v2[i];
      m_b[i] = d2 * q2[i+1];
      m_e[i] = q2[0] * cr2[i];
    end
  end

  // magnitude and saturation threshold
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_mag[i] = num4[i][NUM_W-1] ? -num4[i] : num4[i];
      m_lim[i] = {3'b0, dv6, 31'b0} + (neg6[i] ? {34'b0, dv6} : '0);
    end
  end

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < 3; i++) begin
        m_t[k][i]  = {dr[k][i], dxl[k][i][VW-1]};
        m_ge[k][i] = m_t[k][i] >= {1'b0, ddv[k]};
        m_r[k][i]  = m_t[k][i] - {1'b0, ddv[k]};
      end
    end
  end

  // sign, saturation and zero handling of the quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dzero[DIV_STEPS]) begin
        m_res[i] = '0;
      end else if (dsat[DIV_STEPS][i]) begin
        m_res[i] = dneg[DIV_STEPS][i] ? NEG_LIM : POS_LIM;
      end else begin
        m_res[i] = dneg[DIV_STEPS][i] ? -dq[DIV_STEPS][i] : dq[DIV_STEPS][i];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      for (int i = 0; i < 4; i++) begin
        sq1[i] <= m_sq[i][30:0];
        q1[i]  <= in_q[i];
      end
      for (int i = 0; i < 3; i++) begin
        pd1[i] <= m_d[i];
        v1[i]  <= in_v[i];
      end
      for (int i = 0; i < 6; i++) begin
        pc1[i] <= m_c[i];
      end

      // stage 2
      n2 <= {2'b0, sq1[0]} + {2'b0, sq1[1]} + {2'b0, sq1[2]} + {2'b0, sq1[3]};
      s2 <= $signed({3'b0, sq1[0]} - {3'b0, sq1[1]} - {3'b0, sq1[2]} - {3'b0, sq1[3]});
      d2 <= pd1[0] + pd1[1] + pd1[2];
      for (int i = 0; i < 3; i++) begin
        cr2[i] <= pc1[2*i] - pc1[2*i+1];
        v2[i]  <= v1[i];
      end
      for (int i = 0; i < 4; i++) begin
        q2[i] <= q1[i];
      end

      // stage 3
      n3 <= n2;
      for (int i = 0; i < 3; i++) begin
        a3[i] <= m_a[i];
        b3[i] <= m_b[i];
        e3[i] <= m_e[i];
      end

      // stage 4
      n4 <= n3;
      for (int i = 0; i < 3; i++) begin
        num4[i] <= a3[i] + (b3[i] <<< 1) + (e3[i] <<< 1);
      end

      // stage 5
      n5 <= n4;
      for (int i = 0; i < 3; i++) begin
        neg5[i] <= num4[i][NUM_W-1];
        mag5[i] <= m_mag[i][MAG_W-1:0];
      end

      // stage 6
      dv6   <= {n5, 1'b0};
      neg6  <= neg5;
      zero6 <= (n5 == '0);
      for (int i = 0; i < 3; i++) begin
        x6[i] <= {mag5[i], 1'b0} + {35'b0, n5};
      end

      // divider load
      ddv[0]   <= dv6;
      dneg[0]  <= neg6;
      dzero[0] <= zero6;
      for (int i = 0; i < 3; i++) begin
        dsat[0][i] <= x6[i] >= m_lim[i];
        dr[0][i]   <= x6[i][VW +: DIV_W];
        dxl[0][i]  <= x6[i][VW-1:0];
        dq[0][i]   <= '0;
      end

      // divider steps
      for (int k = 0; k < DIV_STEPS; k++) begin
        ddv[k+1]   <= ddv[k];
        dneg[k+1]  <= dneg[k];
        dsat[k+1]  <= dsat[k];
        dzero[k+1] <= dzero[k];
        for (int i = 0; i < 3; i++) begin
          dr[k+1][i]  <= m_ge[k][i] ? m_r[k][i][DIV_W-1:0] : m_t[k][i][DIV_W-1:0];
          dxl[k+1][i] <= {dxl[k][i][VW-2:0], 1'b0};
          dq[k+1][i]  <= {dq[k][i][VW-2:0], m_ge[k][i]};
        end
      end

      // output
      for (int i = 0; i < 3; i++) begin
        rot[i] <= m_res[i];
      end
      if (dzero[DIV_STEPS]) begin
        stat <= STAT_ZERO;
      end else if (dsat[DIV_STEPS] != 3'b0) begin
        stat <= STAT_SAT;
      end else begin
        stat <= STAT_OK;
      end
    end
  end

  // zero quaternion gives a zero vector
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_ZERO) |-> (m_tdata == '0))
    else $error("zero quaternion with nonzero vector");

  // saturation status means some component sits at a limit
  a_sat_lim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_SAT) |->
      (m_tdata[31:0] == POS_LIM) || (m_tdata[31:0] == NEG_LIM) ||
      (m_tdata[63:32] == POS_LIM) || (m_tdata[63:32] == NEG_LIM) ||
      (m_tdata[95:64] == POS_LIM) || (m_tdata[95:64] == NEG_LIM))
    else $error("saturation status without a clamped component");

  // a result leaves only after the stage before the output held an item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld[LAT-2]))
    else $error("result without a source item");

endmodule
